@@ rtl/salc_pkg.sv @@
// Shared types, codes and constants of the set-associative LRU cache model.
`default_nettype none
package salc_pkg;

    localparam int MAX_WAYS_DEF     = 8;
    localparam int MAX_SET_BITS_DEF = 6;

    localparam int SET_BITS_W   = 3;
    localparam int WAYS_W       = 4;
    localparam int BLOCK_BITS_W = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 2;

    localparam int ADDR_W       = 32;
    localparam int TOTAL_W      = 32;
    localparam int OUTCOME_W    = 2;
    localparam int OP_W         = 2;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 104;

    localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
    localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAYS       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_IFETCH = 2'd0,
        OP_LOAD   = 2'd1,
        OP_STORE  = 2'd2,
        OP_MODIFY = 2'd3
    } op_t;

    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  tag;
        logic [ADDR_W-1:0]  last_use;
    } line_t;

    typedef struct packed {
        logic start;
        logic ent_valid;
    } scan_ctrl_t;

    typedef struct packed {
        logic hit;
        logic free_found;
    } scan_status_t;

    function automatic int way_w(input int ways);
        return (ways > 1) ? $clog2(ways) : 1;
    endfunction

endpackage
`default_nettype wire

@@ rtl/salc_way_scan.sv @@
// Shared tag compare and age unit that walks the ways of one set, one per cycle.
`default_nettype none
module salc_way_scan #(
    parameter int  MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
    localparam int WAY_W    = salc_pkg::way_w(MAX_WAYS)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  salc_pkg::scan_ctrl_t     ctrl,
    input  salc_pkg::line_t          entry,
    input  logic [WAY_W-1:0]         ent_way,
    input  logic [salc_pkg::ADDR_W-1:0] tag,
    input  logic [salc_pkg::ADDR_W-1:0] now,
    output salc_pkg::scan_status_t   status,
    output logic [WAY_W-1:0]         sel_way
);
    import salc_pkg::*;

    logic              hit_reg, hit_next;
    logic              free_reg, free_next;
    logic              found_reg, found_next;
    logic [WAY_W-1:0]  hit_way_reg, hit_way_next;
    logic [WAY_W-1:0]  free_way_reg, free_way_next;
    logic [WAY_W-1:0]  victim_reg, victim_next;
    logic [ADDR_W-1:0] best_age_reg, best_age_next;
    logic [ADDR_W-1:0] age;

    assign age = now - entry.last_use;

    always_comb begin
        hit_next      = hit_reg;
        free_next     = free_reg;
        found_next    = found_reg;
        hit_way_next  = hit_way_reg;
        free_way_next = free_way_reg;
        victim_next   = victim_reg;
        best_age_next = best_age_reg;
        if (ctrl.start) begin
            hit_next   = 1'b0;
            free_next  = 1'b0;
            found_next = 1'b0;
        end else if (ctrl.ent_valid) begin
            // The first matching way wins; stale duplicates can exist after reconfiguration.
            if (!hit_reg && entry.valid && entry.tag == tag) begin
                hit_next     = 1'b1;
                hit_way_next = ent_way;
            end
            if (!free_reg && !entry.valid) begin
                free_next     = 1'b1;
                free_way_next = ent_way;
            end
            // Strictly greater keeps the lowest way on a tie.
            if (!found_reg || age > best_age_reg) begin
                found_next    = 1'b1;
                best_age_next = age;
                victim_next   = ent_way;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_way_reg  <= hit_way_next;
        free_way_reg <= free_way_next;
        victim_reg   <= victim_next;
        best_age_reg <= best_age_next;
    end

    assign status.hit        = hit_reg;
    assign status.free_found = free_reg;
    assign sel_way = hit_reg ? hit_way_reg : (free_reg ? free_way_reg : victim_reg);

endmodule
`default_nettype wire

@@ rtl/set_assoc_lru_cache_model.sv @@
// A load or store passes through the address split, the set walk through the line memory
// read port and the write back, which waits until the output register is free; a modify
// then gives a second result, a hit, after the first. A new data access is accepted only
// after the last one has given its results; a fetch is accepted while idle and gives none.
// Reset: a clearing pass writes all 2^(MAX_SET_BITS+log2 MAX_WAYS) lines (512 by default)
// invalid; no beat is accepted meanwhile.
`default_nettype none
module set_assoc_lru_cache_model #(
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [salc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [salc_pkg::IN_TDATA_W-1:0]     s_tdata,  // address[31:0]
    input  logic [salc_pkg::OP_W-1:0]           s_tuser,  // operation[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // outcome[1:0], hit_total[33:2], miss_total[65:34], eviction_total[97:66], zeros
    output logic [salc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);
    import salc_pkg::*;

    localparam int WAY_W   = way_w(MAX_WAYS);
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam int SB_W    = $clog2(MAX_SET_BITS + 1);
    localparam int LINE_AW = MAX_SET_BITS + WAY_W;
    localparam int DEPTH   = 2 ** LINE_AW;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_PREP   = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_WRITE  = 6'b010000,
        ST_SECOND = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [WAYS_W-1:0]       ways_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;

    logic [SB_W-1:0]   sb_eff;
    logic [WCNT_W-1:0] ways_eff;

    logic [ADDR_W-1:0]       addr_reg;
    logic                    modify_reg;
    logic [ADDR_W-1:0]       shifted;
    logic [MAX_SET_BITS-1:0] set_next, set_reg;
    logic [ADDR_W-1:0]       tag_next, tag_reg;

    logic [LINE_AW-1:0] clear_cnt_reg;
    logic [WCNT_W-1:0]  issue_cnt_reg;
    logic               issuing;
    logic               pend_reg;
    logic [WAY_W-1:0]   pend_way_reg;

    line_t              line_mem [DEPTH];
    line_t              mem_rdata_reg;
    line_t              mem_wdata;
    logic               mem_we;
    logic [LINE_AW-1:0] mem_waddr;
    logic [LINE_AW-1:0] mem_raddr;

    scan_ctrl_t   scan_ctrl;
    scan_status_t scan_status;
    logic [WAY_W-1:0] sel_way;

    logic [ADDR_W-1:0]  clock_reg;
    logic [TOTAL_W-1:0] hits_reg, misses_reg, evictions_reg;
    logic [TOTAL_W-1:0] hits_inc, misses_inc, evictions_inc;
    logic               m_valid_reg;
    logic [OUTCOME_W-1:0] m_outcome_reg;
    logic               m_last_reg;
    logic               out_free;
    logic               in_beat;
    logic               load_first;
    logic               load_second;
    logic               load_final;
    logic [OUTCOME_W-1:0] first_outcome;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= SET_BITS_RST;
            ways_reg       <= WAYS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                REG_WAYS:       ways_reg       <= cfg_data[WAYS_W-1:0];
                REG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(set_bits_reg) > MAX_SET_BITS) begin
            sb_eff = SB_W'(MAX_SET_BITS);
        end else begin
            sb_eff = SB_W'(set_bits_reg);
        end
        if (ways_reg == '0) begin
            ways_eff = WCNT_W'(1);
        end else if (int'(ways_reg) > MAX_WAYS) begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WCNT_W'(ways_reg);
        end
    end

    // Address split: drop the block offset, then take the set index and the tag.
    assign shifted = addr_reg >> block_bits_reg;
    always_comb begin
        for (int i = 0; i < MAX_SET_BITS; i++) begin
            set_next[i] = shifted[i] & (i < int'(sb_eff));
        end
        tag_next = shifted >> sb_eff;
    end

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign issuing  = (state_reg == ST_SCAN) && (issue_cnt_reg < ways_eff);

    assign load_first  = (state_reg == ST_WRITE) && out_free;
    assign load_second = (state_reg == ST_SECOND) && out_free;
    assign load_final  = (load_first && !modify_reg) || load_second;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clear_cnt_reg == LINE_AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_beat && op_t'(s_tuser) != OP_IFETCH) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: state_next = ST_SCAN;
            ST_SCAN: begin
                if (!issuing && !pend_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = modify_reg ? ST_SECOND : ST_IDLE;
                end
            end
            ST_SECOND: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clear_cnt_reg <= clear_cnt_reg + LINE_AW'(1);
            end
            if (state_reg == ST_PREP) begin
                issue_cnt_reg <= '0;
            end else if (issuing) begin
                issue_cnt_reg <= issue_cnt_reg + WCNT_W'(1);
            end
            pend_reg <= issuing;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            addr_reg   <= s_tdata[ADDR_W-1:0];
            modify_reg <= (op_t'(s_tuser) == OP_MODIFY);
        end
        if (state_reg == ST_PREP) begin
            set_reg <= set_next;
            tag_reg <= tag_next;
        end
        pend_way_reg <= issue_cnt_reg[WAY_W-1:0];
    end

    // Line memory: one line a cycle is read while the set is walked.
    assign mem_raddr = {set_reg, issue_cnt_reg[WAY_W-1:0]};

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_we          = 1'b1;
            mem_waddr       = clear_cnt_reg;
            mem_wdata       = '0;
        end else begin
            mem_we          = load_first;
            mem_waddr       = {set_reg, sel_way};
            mem_wdata.valid    = 1'b1;
            mem_wdata.tag      = tag_reg;
            mem_wdata.last_use = clock_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= line_mem[mem_raddr];
    end

    assign scan_ctrl.start     = (state_reg == ST_PREP);
    assign scan_ctrl.ent_valid = pend_reg;

    salc_way_scan #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (scan_ctrl),
        .entry   (mem_rdata_reg),
        .ent_way (pend_way_reg),
        .tag     (tag_reg),
        .now     (clock_reg),
        .status  (scan_status),
        .sel_way (sel_way)
    );

    always_comb begin
        if (scan_status.hit) begin
            first_outcome = OUT_HIT;
        end else if (scan_status.free_found) begin
            first_outcome = OUT_MISS;
        end else begin
            first_outcome = OUT_EVICT;
        end
    end

    assign hits_inc      = (hits_reg == '1) ? hits_reg : hits_reg + TOTAL_W'(1);
    assign misses_inc    = (misses_reg == '1) ? misses_reg : misses_reg + TOTAL_W'(1);
    assign evictions_inc = (evictions_reg == '1) ? evictions_reg
                                                 : evictions_reg + TOTAL_W'(1);

    // The totals change only when a result is loaded, so they double as its payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evictions_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (load_first) begin
                if (first_outcome == OUT_HIT) begin
                    hits_reg <= hits_inc;
                end else begin
                    misses_reg <= misses_inc;
                end
                if (first_outcome == OUT_EVICT) begin
                    evictions_reg <= evictions_inc;
                end
            end else if (load_second) begin
                hits_reg <= hits_inc;
            end
            if (load_final) begin
                clock_reg <= clock_reg + ADDR_W'(1);
            end
            if (load_first || load_second) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_first) begin
            m_outcome_reg <= first_outcome;
            m_last_reg    <= !modify_reg;
        end else if (load_second) begin
            m_outcome_reg <= OUT_HIT;
            m_last_reg    <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_TDATA_W'({evictions_reg, misses_reg, hits_reg, m_outcome_reg});

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_valid_reg)
        else $error("result presented during the clearing pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        evictions_reg <= misses_reg)
        else $error("eviction total exceeds miss total");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> hits_reg >= $past(hits_reg))
        else $error("hit total decreased");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> issue_cnt_reg <= ways_eff)
        else $error("set walk ran past the ways in use");

endmodule
`default_nettype wire

@@ tb/salc_checker.sv @@
// Checker for the set-associative LRU cache: predicts every result beat and compares it.
module salc_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [salc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [salc_pkg::IN_TDATA_W-1:0]    s_tdata,   // address[31:0]
    input  logic [salc_pkg::OP_W-1:0]          s_tuser,   // operation[1:0]
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // outcome[1:0], hit_total[33:2], miss_total[65:34], eviction_total[97:66], zeros
    input  logic [salc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               m_tlast,
    output int                                 fail_count,
    output int                                 pending
);
    import salc_pkg::*;

    localparam int NUM_LINES = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic                 last;
        logic [TOTAL_W-1:0]   hits;
        logic [TOTAL_W-1:0]   misses;
        logic [TOTAL_W-1:0]   evictions;
    } access_result_t;

    logic                  line_valid [NUM_LINES];
    logic [ADDR_W-1:0]     line_tag   [NUM_LINES];
    logic [ADDR_W-1:0]     line_stamp [NUM_LINES];
    logic [ADDR_W-1:0]     stamp_clock;
    logic [TOTAL_W-1:0]    hits, misses, evictions;
    logic [SET_BITS_W-1:0]   set_bits_q;
    logic [WAYS_W-1:0]       ways_q;
    logic [BLOCK_BITS_W-1:0] block_bits_q;
    access_result_t        pending_results [$];
    int                    mismatches = 0;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // One lookup of the set; updates the line store and the totals.
    function automatic logic [OUTCOME_W-1:0] cache_lookup(input logic [ADDR_W-1:0] addr);
        int          sb, nways, base, victim;
        logic [63:0] shifted;
        logic [31:0] set_idx, tag, age, oldest;
        sb    = (set_bits_q > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(set_bits_q);
        nways = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS_DEF) ? MAX_WAYS_DEF : int'(ways_q));
        shifted = {32'b0, addr} >> block_bits_q;
        set_idx = 32'(shifted & ((64'd1 << sb) - 64'd1));
        tag     = 32'(shifted >> sb);
        base    = int'(set_idx) * MAX_WAYS_DEF;
        for (int w = 0; w < nways; w++) begin
            if (line_valid[base + w] && line_tag[base + w] == tag) begin
                line_stamp[base + w] = stamp_clock;
                hits = sat_inc(hits);
                return OUT_HIT;
            end
        end
        for (int w = 0; w < nways; w++) begin
            if (!line_valid[base + w]) begin
                line_valid[base + w] = 1'b1;
                line_tag[base + w]   = tag;
                line_stamp[base + w] = stamp_clock;
                misses = sat_inc(misses);
                return OUT_MISS;
            end
        end
        // Evict the line unused for longest; on equal age the lower way wins.
        victim = 0;
        oldest = '0;
        for (int w = 0; w < nways; w++) begin
            age = stamp_clock - line_stamp[base + w];
            if (w == 0 || age > oldest) begin
                oldest = age;
                victim = w;
            end
        end
        line_tag[base + victim]   = tag;
        line_stamp[base + victim] = stamp_clock;
        misses    = sat_inc(misses);
        evictions = sat_inc(evictions);
        return OUT_EVICT;
    endfunction

    always @(posedge aclk) begin
        access_result_t       got, want;
        logic [OUTCOME_W-1:0] oc;
        if (!aresetn) begin
            for (int i = 0; i < NUM_LINES; i++) line_valid[i] = 1'b0;
            stamp_clock  = '0;
            hits         = '0;
            misses       = '0;
            evictions    = '0;
            set_bits_q   = SET_BITS_RST;
            ways_q       = WAYS_RST;
            block_bits_q = BLOCK_BITS_RST;
            pending_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SET_BITS:   set_bits_q   = cfg_data[SET_BITS_W-1:0];
                    REG_WAYS:       ways_q       = cfg_data[WAYS_W-1:0];
                    REG_BLOCK_BITS: block_bits_q = cfg_data[BLOCK_BITS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready && s_tuser != OP_IFETCH) begin
                if (s_tuser == OP_MODIFY) begin
                    oc = cache_lookup(s_tdata);
                    pending_results.push_back('{oc, 1'b0, hits, misses, evictions});
                end
                oc = cache_lookup(s_tdata);
                pending_results.push_back('{oc, 1'b1, hits, misses, evictions});
                stamp_clock = stamp_clock + 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[1:0], m_tlast, m_tdata[33:2], m_tdata[65:34], m_tdata[97:66]};
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat: outcome %0d last %0b hits %0d",
                             $time, got.outcome, got.last, got.hits);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.outcome !== want.outcome || got.last !== want.last ||
                        got.hits !== want.hits || got.misses !== want.misses ||
                        got.evictions !== want.evictions) begin
                        $display("%0t: mismatch: expected outcome %0d last %0b totals %0d/%0d/%0d",
                                 $time, want.outcome, want.last, want.hits, want.misses,
                                 want.evictions);
                        $display("%0t:           actual outcome %0d last %0b totals %0d/%0d/%0d",
                                 $time, got.outcome, got.last, got.hits, got.misses,
                                 got.evictions);
                        mismatches++;
                    end
                end
            end
        end
        pending    <= pending_results.size();
        fail_count <= mismatches;
    end

endmodule

@@ tb/tb_set_assoc_lru_cache_model.sv @@
// Testbench top for the set-associative LRU cache: stimulus, flow control and verdict.
module tb_set_assoc_lru_cache_model;
    import salc_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int DATA_ACCESSES = 1600;
    localparam int RANDOM_PHASES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_RARE} stall_mode_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]         s_tuser   = '0;
    logic                    m_tready  = 1'b0;
    logic                    s_tready;
    logic                    m_tvalid;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;
    int                      fail_count;
    int                      pending;
    int                      cycle_count = 0;
    int                      burst_left  = 0;
    bit                      hold_now    = 1'b0;
    int                      cur_sb, cur_ways, cur_bb;

    always #5 aclk = ~aclk;

    set_assoc_lru_cache_model i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    salc_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one beat and waits for it to be taken; bursts end in a short gap.
    task automatic send_access(input op_t op, input logic [ADDR_W-1:0] addr);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    // Stops sending and waits until every result is out and the block has gone quiet.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all three registers, then pokes the unused index, which must be ignored.
    task automatic set_config(input logic [CFG_DATA_W-1:0] sb, input logic [CFG_DATA_W-1:0] ways,
                              input logic [CFG_DATA_W-1:0] bb);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SET_BITS;
        cfg_data  <= sb;
        @(posedge aclk);
        cfg_index <= REG_WAYS;
        cfg_data  <= ways;
        @(posedge aclk);
        cfg_index <= REG_BLOCK_BITS;
        cfg_data  <= bb;
        @(posedge aclk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom_range(0, 31));
        @(posedge aclk);
        cfg_we   <= 1'b0;
        cur_sb   = int'(sb[SET_BITS_W-1:0]);
        cur_ways = int'(ways[WAYS_W-1:0]);
        cur_bb   = int'(bb[BLOCK_BITS_W-1:0]);
    endtask

    // Receiver: segments of different stall patterns, plus one long hold-off on request.
    initial begin
        stall_mode_t mode;
        int          len;
        wait (aresetn);
        forever begin
            if (hold_now) begin
                hold_now = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(posedge aclk);
                    m_tready <= 1'b0;
                end
            end
            mode = stall_mode_t'($urandom_range(0, 3));
            len  = $urandom_range(10, 150);
            repeat (len) begin
                @(posedge aclk);
                case (mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                    READY_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                    default:      m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        op_t           op;
        logic [31:0]   addr;
        logic [63:0]   addr_wide;
        int            eff_sb, eff_ways, set_pick, sent;
        cur_sb   = int'(SET_BITS_RST);
        cur_ways = int'(WAYS_RST);
        cur_bb   = int'(BLOCK_BITS_RST);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: one way, sixteen sets, sixteen-byte blocks.
        send_access(OP_IFETCH, 32'h0000_0000);
        send_access(OP_LOAD,   32'h0000_0000);
        send_access(OP_STORE,  32'h0000_000F);
        send_access(OP_MODIFY, 32'h0000_0000);
        send_access(OP_LOAD,   32'h0000_0100);
        send_access(OP_MODIFY, 32'hFFFF_FFFF);
        send_access(OP_STORE,  32'hFFFF_FFF0);

        // Zero set bits, zero ways and the widest offset: a single line keyed by bit 31.
        drain_and_settle();
        set_config(5'd0, 5'd0, 5'd31);
        send_access(OP_LOAD,   32'hFFFF_FFFF);
        send_access(OP_LOAD,   32'h7FFF_FFFF);
        send_access(OP_MODIFY, 32'h8000_0000);
        send_access(OP_IFETCH, 32'hFFFF_FFFF);

        // Oversized set bits and ways saturate; nine tags into one set force an eviction.
        drain_and_settle();
        set_config(5'd7, 5'd15, 5'd0);
        for (int k = 0; k < 9; k++) send_access(OP_LOAD, 32'(k) << 6);
        send_access(OP_LOAD, 32'h0000_0040);
        send_access(OP_LOAD, 32'h0000_0000);

        drain_and_settle();
        set_config(5'd1, 5'd1, 5'd1);
        send_access(OP_LOAD,  32'h0000_0004);
        send_access(OP_STORE, 32'h0000_000C);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_and_settle();
            set_config(CFG_DATA_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom_range(0, 15)),
                       ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 31))
                                                   : CFG_DATA_W'($urandom_range(0, 10)));
            if (ph == 1) hold_now = 1'b1;
            eff_sb   = (cur_sb > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cur_sb;
            eff_ways = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : cur_ways);
            sent = 0;
            while (sent < DATA_ACCESSES / RANDOM_PHASES) begin
                op = op_t'($urandom_range(0, 3));
                if ($urandom_range(0, 9) < 8) begin
                    // A few sets and a few more tags than ways, so lines are reused and evicted.
                    set_pick  = $urandom_range(0, 3) & ((1 << eff_sb) - 1);
                    addr_wide = ((64'($urandom_range(0, eff_ways + 2)) << eff_sb)
                                 | 64'(set_pick)) << cur_bb;
                    addr = addr_wide[31:0] | ($urandom() & ((32'd1 << cur_bb) - 32'd1));
                end else begin
                    addr = $urandom();
                end
                send_access(op, addr);
                sent++;
            end
        end

        drain_and_settle();
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/salc_pkg.sv
rtl/salc_way_scan.sv
rtl/set_assoc_lru_cache_model.sv
tb/salc_checker.sv
tb/tb_set_assoc_lru_cache_model.sv
